// ===== sv/dwc7_pkg.sv =====
package dwc7_pkg;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int KER_DIM  = 7;
    localparam int KER_PAD  = 3;
    localparam int KER_TAPS = 49;
    localparam int KER_LAST = 48;
    localparam int FRAC_SHIFT = 13;
    localparam int ACC_W = 40;

    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_LOAD_PIXEL  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE     = 2'd2;

    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_BIAS    = 3'd2;
    localparam logic [2:0] CFG_PAD     = 3'd3;
    localparam logic [2:0] CFG_ACT_MIN = 3'd4;
    localparam logic [2:0] CFG_ACT_MAX = 3'd5;
endpackage

// ===== sv/dwc7_ram.sv =====
module dwc7_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== sv/depthwise_conv7x7_flipped_unit.sv =====
// A compute transaction delivers its result once all taps have drained; an out-of-range
// compute delivers a flagged zero result directly from idle. Loads give no result.
// A new transaction is accepted only in idle with no result pending: the 49 taps go
// through one memory read port and one MAC, two drain stages and the output handshake.
// Reset (synchronous, active low) returns control state and configuration to defaults;
// memory contents stay undefined until written.
module depthwise_conv7x7_flipped_unit
    import dwc7_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], row[7:2], col[13:8], weight_index[19:14], value[35:20], zeros
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[15:0]
    output logic [15:0] m_axis_tdata,
    // out_of_range
    output logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int PAW = XW + YW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  in_cmd;
    logic [5:0]  in_row, in_col, in_widx;
    logic [15:0] in_val;
    assign in_cmd  = s_axis_tdata[1:0];
    assign in_row  = s_axis_tdata[7:2];
    assign in_col  = s_axis_tdata[13:8];
    assign in_widx = s_axis_tdata[19:14];
    assign in_val  = s_axis_tdata[35:20];

    logic [6:0]  r_width, r_height;
    logic signed [15:0] r_bias, r_pad, r_min, r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 7'd64; r_height <= 7'd64;
            r_bias <= '0; r_pad <= '0;
            r_min <= 16'sh8000; r_max <= 16'sh7fff;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH:   r_width  <= i_cfg_wdata[6:0];
                CFG_HEIGHT:  r_height <= i_cfg_wdata[6:0];
                CFG_BIAS:    r_bias   <= i_cfg_wdata;
                CFG_PAD:     r_pad    <= i_cfg_wdata;
                CFG_ACT_MIN: r_min    <= i_cfg_wdata;
                CFG_ACT_MAX: r_max    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective plane size saturates to the store.
    logic [10:0] eff_w, eff_h;
    assign eff_w = ({4'd0, r_width} > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : {4'd0, r_width};
    assign eff_h = ({4'd0, r_height} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {4'd0, r_height};

    logic [1:0]  r_state;
    logic [5:0]  r_row, r_col;
    logic [5:0]  r_tap;       // tap being addressed
    logic [2:0]  r_ky, r_kx;
    logic        r_rd_vld, r_rd_pad;   // memory read data is valid / is a padding tap
    logic signed [ACC_W-1:0] r_acc;
    logic        r_ovld;
    logic [15:0] r_odata;
    logic        r_oflag;

    logic accept;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovld;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Tap address generation.
    logic signed [11:0] tr, tc;
    logic tap_pad;
    assign tr = $signed({6'd0, r_row}) + $signed({9'd0, r_ky}) - 12'sd3;
    assign tc = $signed({6'd0, r_col}) + $signed({9'd0, r_kx}) - 12'sd3;
    assign tap_pad = tr < 0 || tc < 0 || tr >= $signed({1'b0, eff_h})
                  || tc >= $signed({1'b0, eff_w});

    logic [PAW-1:0] pix_raddr, pix_waddr;
    logic [5:0]     w_raddr;
    logic [15:0]    pix_rd, w_rd;
    logic pix_we, w_we;
    logic [11:0] tr_u, tc_u;
    assign tr_u = tr;
    assign tc_u = tc;
    assign pix_raddr = {tr_u[YW-1:0], tc_u[XW-1:0]};
    assign w_raddr = 6'(KER_LAST) - r_tap;
    assign pix_we = accept && in_cmd == CMD_LOAD_PIXEL
                 && 11'(in_row) < 11'(MAX_HEIGHT) && 11'(in_col) < 11'(MAX_WIDTH);
    assign w_we = accept && in_cmd == CMD_LOAD_WEIGHT && in_widx <= 6'(KER_LAST);
    assign pix_waddr = {YW'(in_row), XW'(in_col)};

    // The pixel address is {row, col}, so the store spans the full address space.
    dwc7_ram #(.WIDTH(16), .DEPTH(2 ** PAW)) u_pix (
        .i_clk(i_clk), .i_we(pix_we), .i_waddr(pix_waddr), .i_wdata(in_val),
        .i_raddr(pix_raddr), .o_rdata(pix_rd));
    dwc7_ram #(.WIDTH(16), .DEPTH(64)) u_wt (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(in_widx), .i_wdata(in_val),
        .i_raddr(w_raddr), .o_rdata(w_rd));

    logic signed [15:0] px;
    logic signed [31:0] r_prod;
    logic        r_prod_vld;
    assign px = r_rd_pad ? r_pad : $signed(pix_rd);

    logic signed [ACC_W-1:0] q;
    logic signed [15:0] clamped;
    assign q = r_acc >>> FRAC_SHIFT;
    always_comb begin
        logic signed [ACC_W-1:0] t;
        t = q;
        if (t < ACC_W'(r_min)) t = ACC_W'(r_min);
        if (t > ACC_W'(r_max)) t = ACC_W'(r_max);
        clamped = t[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ovld <= 1'b0;
            r_rd_vld <= 1'b0; r_prod_vld <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            r_rd_vld <= 1'b0;
            r_prod_vld <= r_rd_vld;
            r_prod <= px * $signed(w_rd);
            r_rd_pad <= tap_pad;
            if (r_prod_vld) r_acc <= r_acc + ACC_W'(r_prod);
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && in_cmd == CMD_COMPUTE) begin
                        if (11'(in_row) >= eff_h || 11'(in_col) >= eff_w) begin
                            r_ovld <= 1'b1; r_odata <= '0; r_oflag <= 1'b1;
                        end else begin
                            r_state <= ST_RUN;
                            r_row <= in_row; r_col <= in_col;
                            r_tap <= '0; r_ky <= '0; r_kx <= '0;
                            r_acc <= ACC_W'(r_bias) <<< FRAC_SHIFT;
                        end
                    end
                end
                ST_RUN: begin
                    r_rd_vld <= 1'b1;
                    r_tap <= r_tap + 6'd1;
                    if (r_kx == 3'(KER_DIM - 1)) begin
                        r_kx <= '0; r_ky <= r_ky + 3'd1;
                    end else begin
                        r_kx <= r_kx + 3'd1;
                    end
                    if (r_tap == 6'(KER_LAST)) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_rd_vld && !r_prod_vld) begin
                        r_ovld <= 1'b1; r_odata <= clamped; r_oflag <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oflag;
endmodule
